@@ hw/rtl/iab_pkg.sv @@
// shared types, constants and arithmetic helpers for the rgb444 alpha blender
// no dependencies
`timescale 1ns / 1ps

package iab_pkg;

    localparam int unsigned NIB_W   = 4;
    localparam int unsigned PIX_W   = 12;
    localparam int unsigned SRC_W   = 16;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned SUM_W   = 8;
    localparam int unsigned CHANNELS = 3;

    localparam logic [NIB_W-1:0] NIB_MAX = 4'hF;

    localparam logic [IDX_W-1:0] REG_BLEND_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_FORE_COLOR = 2'd1;
    localparam logic [IDX_W-1:0] REG_BACK_COLOR = 2'd2;

    localparam logic [PIX_W-1:0] FORE_RESET = 12'hFFF;
    localparam logic [PIX_W-1:0] BACK_RESET = 12'h000;

    typedef struct packed {
        logic             blend_mode;
        logic [PIX_W-1:0] fore_color;
        logic [PIX_W-1:0] back_color;
    } cfg_t;

    typedef logic [SUM_W-1:0] sum_arr_t [CHANNELS];

    // x*w + y*(15-w), at most 225
    function automatic logic [SUM_W-1:0] mix_sum(
        input logic [NIB_W-1:0] x,
        input logic [NIB_W-1:0] y,
        input logic [NIB_W-1:0] w
    );
        logic [SUM_W-1:0] px;
        logic [SUM_W-1:0] py;
        px = SUM_W'(x) * SUM_W'(w);
        py = SUM_W'(y) * SUM_W'(NIB_MAX - w);
        return px + py;
    endfunction

    // floor(x/15) for x <= 225 via (x+1)*17 >> 8
    function automatic logic [NIB_W-1:0] div15(input logic [SUM_W-1:0] x);
        logic [12:0] prod;
        prod = (13'(x) + 13'd1) * 13'd17;
        return prod[11:8];
    endfunction

endpackage

@@ hw/rtl/iab_cfg_regs.sv @@
// configuration registers: blend mode, foreground and background colors
// depends on iab_pkg
`timescale 1ns / 1ps

module iab_cfg_regs
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [iab_pkg::IDX_W-1:0] cfg_index,
    input  logic [iab_pkg::CFG_W-1:0] cfg_data,
    output iab_pkg::cfg_t             cfg
);

    iab_pkg::cfg_t cfg_reg;
    iab_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                iab_pkg::REG_BLEND_MODE: cfg_next.blend_mode = cfg_data[0];
                iab_pkg::REG_FORE_COLOR: cfg_next.fore_color = cfg_data;
                iab_pkg::REG_BACK_COLOR: cfg_next.back_color = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_mode <= 1'b0;
            cfg_reg.fore_color <= iab_pkg::FORE_RESET;
            cfg_reg.back_color <= iab_pkg::BACK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/iab_color_stage.sv @@
// pipeline stages 1-2: coverage interpolation and source color selection
// depends on iab_pkg
`timescale 1ns / 1ps

module iab_color_stage
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      valid_in,
    input  logic [iab_pkg::SRC_W-1:0] source_word,
    input  logic [iab_pkg::PIX_W-1:0] dest_pixel,
    input  iab_pkg::cfg_t             cfg,
    output logic                      valid_out,
    output logic [iab_pkg::PIX_W-1:0] col_out,
    output logic [iab_pkg::NIB_W-1:0] alpha_out,
    output logic [iab_pkg::PIX_W-1:0] dest_out
);

    // stage 1
    logic                      v1_reg;
    logic                      mode1_reg;
    logic [iab_pkg::NIB_W-1:0] alpha1_reg;
    logic [iab_pkg::PIX_W-1:0] srccol1_reg;
    logic [iab_pkg::PIX_W-1:0] dest1_reg;
    iab_pkg::sum_arr_t         sum1_reg;
    iab_pkg::sum_arr_t         sum1_next;
    logic [iab_pkg::NIB_W-1:0] alpha1_next;

    // stage 2
    logic                      v2_reg;
    logic [iab_pkg::PIX_W-1:0] col2_reg;
    logic [iab_pkg::PIX_W-1:0] col2_next;
    logic [iab_pkg::NIB_W-1:0] alpha2_reg;
    logic [iab_pkg::PIX_W-1:0] dest2_reg;

    always_comb
    begin
        for (int ch = 0; ch < iab_pkg::CHANNELS; ch++)
        begin
            sum1_next[ch] = iab_pkg::mix_sum(cfg.fore_color[ch*4 +: 4],
                                             cfg.back_color[ch*4 +: 4],
                                             source_word[3:0]);
        end
        alpha1_next = cfg.blend_mode ? source_word[15:12] : source_word[7:4];
    end

    always_comb
    begin
        for (int ch = 0; ch < iab_pkg::CHANNELS; ch++)
        begin
            col2_next[ch*4 +: 4] = mode1_reg ? srccol1_reg[ch*4 +: 4]
                                             : iab_pkg::div15(sum1_reg[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg   <= cfg.blend_mode;
            alpha1_reg  <= alpha1_next;
            srccol1_reg <= source_word[11:0];
            dest1_reg   <= dest_pixel;
            sum1_reg    <= sum1_next;
            col2_reg    <= col2_next;
            alpha2_reg  <= alpha1_reg;
            dest2_reg   <= dest1_reg;
        end
    end

    assign valid_out = v2_reg;
    assign col_out   = col2_reg;
    assign alpha_out = alpha2_reg;
    assign dest_out  = dest2_reg;

endmodule

@@ hw/rtl/iab_blend_stage.sv @@
// pipeline stages 3-4: blend source color over destination by alpha
// depends on iab_pkg
`timescale 1ns / 1ps

module iab_blend_stage
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      valid_in,
    input  logic [iab_pkg::PIX_W-1:0] col_in,
    input  logic [iab_pkg::NIB_W-1:0] alpha_in,
    input  logic [iab_pkg::PIX_W-1:0] dest_in,
    output logic                      valid_out,
    output logic [iab_pkg::PIX_W-1:0] pixel_out
);

    logic                      v3_reg;
    iab_pkg::sum_arr_t         sum3_reg;
    iab_pkg::sum_arr_t         sum3_next;
    logic                      v4_reg;
    logic [iab_pkg::PIX_W-1:0] pix4_reg;
    logic [iab_pkg::PIX_W-1:0] pix4_next;

    always_comb
    begin
        for (int ch = 0; ch < iab_pkg::CHANNELS; ch++)
        begin
            sum3_next[ch] = iab_pkg::mix_sum(col_in[ch*4 +: 4],
                                             dest_in[ch*4 +: 4], alpha_in);
            pix4_next[ch*4 +: 4] = iab_pkg::div15(sum3_reg[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= valid_in;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum3_reg <= sum3_next;
            pix4_reg <= pix4_next;
        end
    end

    assign valid_out = v4_reg;
    assign pixel_out = pix4_reg;

endmodule

@@ hw/rtl/image_alpha_blend_rgb444_top.sv @@
// rgb444 alpha blender top level: pipeline control and stage wiring
// depends on iab_pkg, iab_cfg_regs, iab_color_stage, iab_blend_stage
//
// usage
//   input channel: in_valid/in_stall with source_word and dest_pixel; a
//   transaction completes on a rising edge with in_valid high, in_stall low
//   output channel: out_valid/out_stall with blended_pixel, same rule
//   config port: cfg_we writes cfg_data to register cfg_index
//   (0 blend_mode, 1 fore_color, 2 back_color, index 3 ignored); write only
//   while the pipeline is empty
//   latency: 4 cycles from input transaction to out_valid
//   throughput: one pixel per cycle, set by the four-stage pipeline
//   stall: out_stall with a valid result freezes all stages and raises
//   in_stall in the same cycle; nothing is lost or repeated
//   reset: pipeline empty, blend_mode 0, fore_color 0xfff, back_color 0
`timescale 1ns / 1ps

module image_alpha_blend_rgb444_top
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [iab_pkg::IDX_W-1:0] cfg_index,
    input  logic [iab_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [iab_pkg::SRC_W-1:0] source_word,
    input  logic [iab_pkg::PIX_W-1:0] dest_pixel,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [iab_pkg::PIX_W-1:0] blended_pixel
);

    iab_pkg::cfg_t             cfg;
    logic                      adv;
    logic                      mid_valid;
    logic [iab_pkg::PIX_W-1:0] mid_col;
    logic [iab_pkg::NIB_W-1:0] mid_alpha;
    logic [iab_pkg::PIX_W-1:0] mid_dest;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    iab_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iab_color_stage u_color
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .valid_in    (in_valid),
        .source_word (source_word),
        .dest_pixel  (dest_pixel),
        .cfg         (cfg),
        .valid_out   (mid_valid),
        .col_out     (mid_col),
        .alpha_out   (mid_alpha),
        .dest_out    (mid_dest)
    );

    iab_blend_stage u_blend
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (mid_valid),
        .col_in    (mid_col),
        .alpha_in  (mid_alpha),
        .dest_in   (mid_dest),
        .valid_out (out_valid),
        .pixel_out (blended_pixel)
    );

endmodule
